@@ rtl/look_at_view_matrix_macros.svh @@
// ----------------------------------------------------------------------------
// look_at_view_matrix_macros.svh
// Assertion helpers for the look-at view matrix block.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// checked only out of reset
`define LVM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset too
`define LVM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/lvm_pkg.sv @@
// ----------------------------------------------------------------------------
// lvm_pkg
// Shared widths, types and helpers of the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lvm_pkg;

    localparam int COORD_W = 32;
    localparam int EFF_W   = (COORD_W < 16) ? 16 : ((COORD_W > 32) ? 32 : COORD_W);
    localparam int FIELD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int VEC_W   = 52;
    localparam int UNIT_W  = FRAC_W + 2;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (EFF_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef logic [2:0][FIELD_W-1:0] t_coord3;
    typedef logic [2:0][VEC_W-1:0]   t_nvec;
    typedef logic [2:0][UNIT_W-1:0]  t_unit3;

    typedef struct packed {
        t_coord3 eye;
        t_coord3 up;
        t_unit3  f;
        t_unit3  r;
    } t_side;

    typedef struct packed {
        t_coord3 right;
        t_coord3 true_up;
        t_coord3 back;
        t_coord3 shift;
    } t_view;

    function automatic logic [FIELD_W-1:0] load_coord(input logic [FIELD_W-1:0] raw);
        logic signed [EFF_W-1:0] v;
        v = raw[EFF_W-1:0];
        return FIELD_W'(v);
    endfunction

    function automatic logic [FIELD_W-1:0] sat_coord(input logic signed [63:0] x);
        logic [FIELD_W-1:0] res;
        if (x > SAT_HI) begin
            res = SAT_HI[FIELD_W-1:0];
        end else if (x < SAT_LO) begin
            res = SAT_LO[FIELD_W-1:0];
        end else begin
            res = x[FIELD_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/look_at_view_matrix.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Look-at view matrix in Q16.16: right, true up and back rows plus the three
// saturated translations, from an eye, a target and an up hint.
//
// Input channel i_valid/o_ready carries one word of nine coordinates; output
// channel o_valid/i_ready carries one word of twelve matrix entries.
// Throughput: one word per cycle while the receiver holds i_ready high. A
// word passes 106 register stages, the first loaded at the accepting edge:
// three 33-stage normalize pipelines (bit pairs of the square root and of
// the 17-bit divide, one pair per stage), two 2-stage cross products and
// the 3-stage dot and saturate tail.
// Every stage holds a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles close up and the input keeps accepting
// while a finished word waits. When the receiver stalls the pipe fills and
// o_ready drops only once every stage holds a word; nothing is lost.
// Reset (synchronous, active low) clears all valid bits; the pipeline comes
// up empty and ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_macros.svh"

module look_at_view_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_eye_x,
    input  logic signed [31:0] i_eye_y,
    input  logic signed [31:0] i_eye_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_up_hint_x,
    input  logic signed [31:0] i_up_hint_y,
    input  logic signed [31:0] i_up_hint_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_right_x,
    output logic signed [31:0] o_right_y,
    output logic signed [31:0] o_right_z,
    output logic signed [31:0] o_true_up_x,
    output logic signed [31:0] o_true_up_y,
    output logic signed [31:0] o_true_up_z,
    output logic signed [31:0] o_back_x,
    output logic signed [31:0] o_back_y,
    output logic signed [31:0] o_back_z,
    output logic signed [31:0] o_shift_right,
    output logic signed [31:0] o_shift_up,
    output logic signed [31:0] o_shift_back
);
    import lvm_pkg::*;

    t_coord3 eye, tgt, up;
    t_nvec   d;
    t_side   s_in;

    logic    n1_valid, n1_ready;
    t_unit3  n1_vec;
    t_side   n1_side, c1_side_in;
    logic    c1_valid, c1_ready;
    t_nvec   c1_vec;
    t_side   c1_side;
    logic    n2_valid, n2_ready;
    t_unit3  n2_vec;
    t_side   n2_side, c2_side_in;
    t_coord3 f_ext;
    logic    c2_valid, c2_ready;
    t_nvec   c2_vec;
    t_side   c2_side;
    logic    n3_valid, n3_ready;
    t_unit3  n3_vec;
    t_side   n3_side;
    logic    dt_ready;
    t_view   view;

    always_comb begin
        eye[0] = load_coord(i_eye_x);
        eye[1] = load_coord(i_eye_y);
        eye[2] = load_coord(i_eye_z);
        tgt[0] = load_coord(i_target_x);
        tgt[1] = load_coord(i_target_y);
        tgt[2] = load_coord(i_target_z);
        up[0]  = load_coord(i_up_hint_x);
        up[1]  = load_coord(i_up_hint_y);
        up[2]  = load_coord(i_up_hint_z);
        for (int i = 0; i < 3; i++) begin
            d[i] = $signed(tgt[i]) - $signed(eye[i]);
        end
        s_in     = '0;
        s_in.eye = eye;
        s_in.up  = up;
    end

    lvm_norm u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_vec   (d),
        .i_side  (s_in),
        .o_valid (n1_valid),
        .i_ready (c1_ready),
        .o_vec   (n1_vec),
        .o_side  (n1_side)
    );

    always_comb begin
        c1_side_in   = n1_side;
        c1_side_in.f = n1_vec;
    end

    lvm_cross u_cross_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n1_valid),
        .o_ready (c1_ready),
        .i_a     (n1_vec),
        .i_b     (n1_side.up),
        .i_side  (c1_side_in),
        .o_valid (c1_valid),
        .i_ready (n2_ready),
        .o_vec   (c1_vec),
        .o_side  (c1_side)
    );

    lvm_norm u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c1_valid),
        .o_ready (n2_ready),
        .i_vec   (c1_vec),
        .i_side  (c1_side),
        .o_valid (n2_valid),
        .i_ready (c2_ready),
        .o_vec   (n2_vec),
        .o_side  (n2_side)
    );

    always_comb begin
        c2_side_in   = n2_side;
        c2_side_in.r = n2_vec;
        for (int i = 0; i < 3; i++) begin
            f_ext[i] = FIELD_W'($signed(n2_side.f[i]));
        end
    end

    lvm_cross u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n2_valid),
        .o_ready (c2_ready),
        .i_a     (n2_vec),
        .i_b     (f_ext),
        .i_side  (c2_side_in),
        .o_valid (c2_valid),
        .i_ready (n3_ready),
        .o_vec   (c2_vec),
        .o_side  (c2_side)
    );

    lvm_norm u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c2_valid),
        .o_ready (n3_ready),
        .i_vec   (c2_vec),
        .i_side  (c2_side),
        .o_valid (n3_valid),
        .i_ready (dt_ready),
        .o_vec   (n3_vec),
        .o_side  (n3_side)
    );

    lvm_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n3_valid),
        .o_ready (dt_ready),
        .i_r     (n3_side.r),
        .i_u     (n3_vec),
        .i_f     (n3_side.f),
        .i_eye   (n3_side.eye),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_view  (view)
    );

    assign o_right_x     = view.right[0];
    assign o_right_y     = view.right[1];
    assign o_right_z     = view.right[2];
    assign o_true_up_x   = view.true_up[0];
    assign o_true_up_y   = view.true_up[1];
    assign o_true_up_z   = view.true_up[2];
    assign o_back_x      = view.back[0];
    assign o_back_y      = view.back[1];
    assign o_back_z      = view.back[2];
    assign o_shift_right = view.shift[0];
    assign o_shift_up    = view.shift[1];
    assign o_shift_back  = view.shift[2];

    `LVM_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_valid, "output valid right after reset")
    `LVM_ASSERT(a_unit_range,
        o_valid |-> (o_back_x <= 32'sd65536 && o_back_x >= -32'sd65536),
        "back axis out of unit range")
    `LVM_ASSERT(a_zero_right,
        (o_valid && o_right_x == 32'sd0 && o_right_y == 32'sd0 && o_right_z == 32'sd0)
            |-> (o_true_up_x == 32'sd0 && o_true_up_y == 32'sd0 && o_true_up_z == 32'sd0
                 && o_shift_right == 32'sd0 && o_shift_up == 32'sd0),
        "zero right axis with nonzero up row")

endmodule

@@ rtl/lvm_norm.sv @@
// ----------------------------------------------------------------------------
// lvm_norm
// Pipelined vector normalize: scale to a 30-bit top, digit-by-digit square
// root, restoring divide to Q2.16; 33 stages, one word/cycle if unstalled.
// ----------------------------------------------------------------------------
module lvm_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lvm_pkg::t_nvec i_vec,
    input  lvm_pkg::t_side i_side,
    output logic           o_valid,
    input  logic           i_ready,
    output lvm_pkg::t_unit3 o_vec,
    output lvm_pkg::t_side o_side
);
    import lvm_pkg::*;

    localparam int MAG_W  = 64;
    localparam int SCL_W  = 30;
    localparam int SQ_W   = 2 * SCL_W;
    localparam int RT_W   = 63;
    localparam int N_W    = 31;
    localparam int Q_W    = FRAC_W + 1;
    localparam int DR_W   = 48;
    localparam int SH_N   = 3;
    localparam int SQRT_N = 16;
    localparam int DIV_N  = (Q_W + 1) / 2;
    localparam int ST_IN  = 0;
    localparam int ST_ABS = 1;
    localparam int ST_SH  = 2;
    localparam int ST_SQ  = ST_SH + SH_N;
    localparam int ST_SUM = ST_SQ + 1;
    localparam int ST_RT  = ST_SUM + 1;
    localparam int ST_DIV = ST_RT + SQRT_N;
    localparam int ST_OUT = ST_DIV + DIV_N;
    localparam int NS     = ST_OUT + 1;

    typedef struct packed {
        t_side                  side;
        t_nvec                  v;
        logic [2:0]             neg;
        logic                   z;
        logic [2:0][MAG_W-1:0]  mag;
        logic [2:0][SQ_W-1:0]   sq;
        logic [RT_W-1:0]        rem;
        logic [RT_W-1:0]        res;
        logic [2:0][DR_W-1:0]   drem;
        logic [2:0][Q_W-1:0]    q;
        t_unit3                 o;
    } t_nst;

    t_nst            r_st [NS];
    t_nst            n_st [NS];
    logic [NS-1:0]   r_v;
    logic [NS-1:0]   n_v;
    logic [NS-1:0]   adv;

    always_comb begin
        for (int k = NS - 1; k >= 0; k--) begin
            if (k == NS - 1) begin
                adv[k] = !r_v[k] || i_ready;
            end else begin
                adv[k] = !r_v[k] || adv[k+1];
            end
            if (k == 0) begin
                n_v[k] = adv[k] ? i_valid : r_v[k];
            end else begin
                n_v[k] = adv[k] ? r_v[k-1] : r_v[k];
            end
        end
    end

    always_comb begin
        logic [VEC_W-1:0] a;
        logic [MAG_W-1:0] orv;
        logic [RT_W-1:0]  rm;
        logic [RT_W-1:0]  rs;
        logic [RT_W-1:0]  bt;
        logic [DR_W-1:0]  dv;
        logic [N_W-1:0]   nn;
        logic [SCL_W-1:0] sc;
        logic [UNIT_W-1:0] uq;
        int sh;
        int t;
        a   = '0;
        orv = '0;
        rm  = '0;
        rs  = '0;
        bt  = '0;
        dv  = '0;
        nn  = '0;
        sc  = '0;
        uq  = '0;
        sh  = 0;
        t   = 0;
        for (int k = 0; k < NS; k++) begin
            if (k == ST_IN) begin
                n_st[k]      = '0;
                n_st[k].v    = i_vec;
                n_st[k].side = i_side;
            end else begin
                n_st[k] = r_st[k-1];
                if (k == ST_ABS) begin
                    orv = '0;
                    for (int i = 0; i < 3; i++) begin
                        n_st[k].neg[i] = r_st[k-1].v[i][VEC_W-1];
                        a = n_st[k].neg[i] ? (~r_st[k-1].v[i] + 1'b1) : r_st[k-1].v[i];
                        n_st[k].mag[i] = MAG_W'(a);
                        orv = orv | n_st[k].mag[i];
                    end
                    n_st[k].z = (orv == '0);
                end else if (k >= ST_SH && k < ST_SQ) begin
                    for (int h = 0; h < 2; h++) begin
                        sh  = 32 >> (2 * (k - ST_SH) + h);
                        orv = n_st[k].mag[0] | n_st[k].mag[1] | n_st[k].mag[2];
                        if ((orv >> (MAG_W - sh)) == '0) begin
                            for (int i = 0; i < 3; i++) begin
                                n_st[k].mag[i] = n_st[k].mag[i] << sh;
                            end
                        end
                    end
                end else if (k == ST_SQ) begin
                    for (int i = 0; i < 3; i++) begin
                        sc = r_st[k-1].mag[i][MAG_W-1 -: SCL_W];
                        n_st[k].sq[i] = SQ_W'(sc) * SQ_W'(sc);
                    end
                end else if (k == ST_SUM) begin
                    n_st[k].rem = RT_W'(r_st[k-1].sq[0]) + RT_W'(r_st[k-1].sq[1])
                                + RT_W'(r_st[k-1].sq[2]);
                    n_st[k].res = '0;
                end else if (k >= ST_RT && k < ST_DIV) begin
                    rm = r_st[k-1].rem;
                    rs = r_st[k-1].res;
                    for (int h = 0; h < 2; h++) begin
                        t  = 2 * (k - ST_RT) + h;
                        bt = RT_W'(1) << (RT_W - 1 - 2 * t);
                        if (rm >= rs + bt) begin
                            rm = rm - (rs + bt);
                            rs = (rs >> 1) + bt;
                        end else begin
                            rs = rs >> 1;
                        end
                    end
                    n_st[k].rem = rm;
                    n_st[k].res = rs;
                end else if (k >= ST_DIV && k < ST_OUT) begin
                    nn = r_st[k-1].res[N_W-1:0];
                    if (k == ST_DIV) begin
                        n_st[k].q = '0;
                        for (int i = 0; i < 3; i++) begin
                            sc = r_st[k-1].mag[i][MAG_W-1 -: SCL_W];
                            n_st[k].drem[i] = (DR_W'(sc) << FRAC_W) + DR_W'(nn >> 1);
                        end
                    end
                    for (int h = 0; h < 2; h++) begin
                        t = 2 * (k - ST_DIV) + h;
                        if (t < Q_W) begin
                            dv = DR_W'(nn) << (Q_W - 1 - t);
                            for (int i = 0; i < 3; i++) begin
                                if (n_st[k].drem[i] >= dv) begin
                                    n_st[k].drem[i] = n_st[k].drem[i] - dv;
                                    n_st[k].q[i][Q_W-1-t] = 1'b1;
                                end
                            end
                        end
                    end
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        uq = UNIT_W'(r_st[k-1].q[i]);
                        if (r_st[k-1].z) begin
                            n_st[k].o[i] = '0;
                        end else if (r_st[k-1].neg[i]) begin
                            n_st[k].o[i] = ~uq + 1'b1;
                        end else begin
                            n_st[k].o[i] = uq;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[NS-1];
    assign o_vec   = r_st[NS-1].o;
    assign o_side  = r_st[NS-1].side;

endmodule

@@ rtl/lvm_cross.sv @@
// ----------------------------------------------------------------------------
// lvm_cross
// Two-stage cross product of a unit vector with a coordinate vector.
// ----------------------------------------------------------------------------
module lvm_cross (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lvm_pkg::t_unit3 i_a,
    input  lvm_pkg::t_coord3 i_b,
    input  lvm_pkg::t_side  i_side,
    output logic            o_valid,
    input  logic            i_ready,
    output lvm_pkg::t_nvec  o_vec,
    output lvm_pkg::t_side  o_side
);
    import lvm_pkg::*;

    localparam int PROD_W = UNIT_W + FIELD_W;

    logic [5:0][PROD_W-1:0] r_p;
    t_side                  r_side0;
    t_nvec                  r_c;
    t_side                  r_side1;
    logic                   r_v0;
    logic                   r_v1;
    logic                   adv0;
    logic                   adv1;

    assign adv1 = !r_v1 || i_ready;
    assign adv0 = !r_v0 || adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (adv0) begin
                r_v0 <= i_valid;
            end
            if (adv1) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_p[0]  <= $signed(i_a[1]) * $signed(i_b[2]);
            r_p[1]  <= $signed(i_a[2]) * $signed(i_b[1]);
            r_p[2]  <= $signed(i_a[2]) * $signed(i_b[0]);
            r_p[3]  <= $signed(i_a[0]) * $signed(i_b[2]);
            r_p[4]  <= $signed(i_a[0]) * $signed(i_b[1]);
            r_p[5]  <= $signed(i_a[1]) * $signed(i_b[0]);
            r_side0 <= i_side;
        end
        if (adv1) begin
            r_c[0]  <= $signed(r_p[0]) - $signed(r_p[1]);
            r_c[1]  <= $signed(r_p[2]) - $signed(r_p[3]);
            r_c[2]  <= $signed(r_p[4]) - $signed(r_p[5]);
            r_side1 <= r_side0;
        end
    end

    assign o_ready = adv0;
    assign o_valid = r_v1;
    assign o_vec   = r_c;
    assign o_side  = r_side1;

endmodule

@@ rtl/lvm_dot.sv @@
// ----------------------------------------------------------------------------
// lvm_dot
// Translation dot products, rounding and saturation of the output matrix.
// ----------------------------------------------------------------------------
module lvm_dot (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  lvm_pkg::t_unit3  i_r,
    input  lvm_pkg::t_unit3  i_u,
    input  lvm_pkg::t_unit3  i_f,
    input  lvm_pkg::t_coord3 i_eye,
    output logic             o_valid,
    input  logic             i_ready,
    output lvm_pkg::t_view   o_view
);
    import lvm_pkg::*;

    localparam int PROD_W = UNIT_W + FIELD_W;
    localparam int DOT_W  = PROD_W + 2;
    localparam logic signed [DOT_W-1:0] RND = DOT_W'(1) <<< (FRAC_W - 1);

    logic [8:0][PROD_W-1:0] r_pr;
    t_unit3                 r_r0, r_u0, r_f0;
    logic [2:0][DOT_W-1:0]  r_y;
    t_unit3                 r_r1, r_u1, r_f1;
    t_view                  r_view;
    t_view                  n_view;
    logic                   r_v0, r_v1, r_v2;
    logic                   adv0, adv1, adv2;

    assign adv2 = !r_v2 || i_ready;
    assign adv1 = !r_v1 || adv2;
    assign adv0 = !r_v0 || adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv0) begin
                r_v0 <= i_valid;
            end
            if (adv1) begin
                r_v1 <= r_v0;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_comb begin
        logic signed [63:0] t;
        n_view = '0;
        for (int i = 0; i < 3; i++) begin
            t = $signed(r_r1[i]);
            n_view.right[i] = sat_coord(t);
            t = $signed(r_u1[i]);
            n_view.true_up[i] = sat_coord(t);
            t = $signed(r_f1[i]);
            n_view.back[i] = sat_coord(-t);
            t = $signed(r_y[i]) >>> FRAC_W;
            n_view.shift[i] = (i == 2) ? sat_coord(t) : sat_coord(-t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            for (int i = 0; i < 3; i++) begin
                r_pr[i]     <= $signed(i_r[i]) * $signed(i_eye[i]);
                r_pr[3 + i] <= $signed(i_u[i]) * $signed(i_eye[i]);
                r_pr[6 + i] <= $signed(i_f[i]) * $signed(i_eye[i]);
            end
            r_r0 <= i_r;
            r_u0 <= i_u;
            r_f0 <= i_f;
        end
        if (adv1) begin
            for (int g = 0; g < 3; g++) begin
                r_y[g] <= $signed(r_pr[3 * g]) + $signed(r_pr[3 * g + 1])
                        + $signed(r_pr[3 * g + 2]) + RND;
            end
            r_r1 <= r_r0;
            r_u1 <= r_u0;
            r_f1 <= r_f0;
        end
        if (adv2) begin
            r_view <= n_view;
        end
    end

    assign o_ready = adv0;
    assign o_valid = r_v2;
    assign o_view  = r_view;

endmodule
